@@ hw/rtl/tpeq_pkg.sv @@
// Shared types, codes and command/status bundles for the touch pointer event queue.
package tpeq_pkg;

    localparam int MAX_CONTACTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 64;

    localparam logic [2:0] OP_DOWN       = 3'd0;
    localparam logic [2:0] OP_MOVE       = 3'd1;
    localparam logic [2:0] OP_UP         = 3'd2;
    localparam logic [2:0] OP_CANCEL     = 3'd3;
    localparam logic [2:0] OP_CANCEL_ALL = 3'd4;
    localparam logic [2:0] OP_DEQUEUE    = 3'd5;

    localparam logic [1:0] PH_DOWN   = 2'd0;
    localparam logic [1:0] PH_MOVE   = 2'd1;
    localparam logic [1:0] PH_UP     = 2'd2;
    localparam logic [1:0] PH_CANCEL = 2'd3;

    localparam logic [2:0] CFG_SCALE_X    = 3'd0;
    localparam logic [2:0] CFG_SCALE_Y    = 3'd1;
    localparam logic [2:0] CFG_OFFSET_X   = 3'd2;
    localparam logic [2:0] CFG_OFFSET_Y   = 3'd3;
    localparam logic [2:0] CFG_MOVE_LIMIT = 3'd4;
    localparam logic [2:0] CFG_ENABLED    = 3'd5;

    localparam logic [23:0] SCALE_RST      = 24'h010000;
    localparam logic [6:0]  MOVE_LIMIT_RST = 7'd64;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] source_device;
        logic [7:0]  source_contact;
        logic [15:0] phys_x;
        logic [15:0] phys_y;
        logic [15:0] press;
        logic [47:0] stamp;
    } t_in_word;

    typedef struct packed {
        logic               has_event;
        logic               overflowed;
        logic [31:0]        seq_number;
        logic [15:0]        gen_number;
        logic [15:0]        pointer_number;
        logic [47:0]        event_stamp;
        logic signed [15:0] guest_x;
        logic signed [15:0] guest_y;
        logic [15:0]        event_press;
        logic [1:0]         event_phase;
    } t_out_word;

    typedef struct packed {
        logic [15:0] gen;
        logic [15:0] ptr;
        logic [1:0]  phase;
    } t_meta;

    typedef struct packed {
        logic [15:0] press;
        logic [15:0] y;
        logic [15:0] x;
    } t_pos;

    typedef struct packed {
        t_meta       meta;
        logic [47:0] stamp;
        t_pos        pos;
        logic [31:0] seq;
    } t_qent;

    typedef struct packed {
        logic [23:0] key;
        logic [15:0] ptr;
        t_pos        pos;
    } t_cent;

    typedef enum logic [1:0] {QA_ZERO, QA_QI, QA_QI_M1, QA_QI_P1} t_qsel;

    typedef struct packed {
        logic  load_item;
        logic  ci_clr;
        logic  ci_inc;
        logic  scan_cmp;
        logic  ca_ev;
        logic  gen_inc;
        logic  down_wr;
        logic  upd_wr;
        logic  ev_start;
        logic  qi_load_cnt;
        logic  qi_clr;
        logic  qi_dec;
        logic  qi_inc;
        logic  mc_dec;
        t_qsel q_sel;
        logic  push;
        logic  rm_wr;
        logic  rm_done;
        logic  out_empty;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       enabled;
        logic       ci_end;
        logic       cvalid;
        logic       hit_ok;
        logic       slot_ok;
        logic       ev_move;
        logic       limit_zero;
        logic       qi_zero;
        logic       qi_at_cnt;
        logic       meta_match;
        logic       rd_move;
        logic       limit_hit;
        logic       q_empty;
        logic       rm_last;
        logic       out_busy;
    } t_stat;

endpackage

@@ hw/rtl/touch_pointer_event_queue.sv @@
// Mapping registers a product, then a rounded, offset and saturated value. The contact scan reads
// and then compares each contact in turn; queue search, eviction and compaction likewise step
// through the queue RAM one entry at a time; dequeues and moves take longer as the queue fills.
// One word is worked at a time; input stall stays high until the word's work is finished.
// Reset (synchronous) clears counters, flags, contact valid bits and config; RAMs are not cleared.
module touch_pointer_event_queue #(
    parameter int MAX_CONTACTS = tpeq_pkg::MAX_CONTACTS_DEF,
    parameter int QUEUE_DEPTH  = tpeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tpeq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpeq_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import tpeq_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    tpeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    tpeq_dp #(
        .MAX_CONTACTS (MAX_CONTACTS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // an accepted word holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous word still in work");

    // an empty-queue result carries only the overflow flag
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.has_event |->
            o_out_word.seq_number == 32'd0 && o_out_word.pointer_number == 16'd0 &&
            o_out_word.event_stamp == 48'd0 && o_out_word.event_phase == PH_DOWN)
        else $error("empty result with nonzero fields");

    // a result only appears while the block is busy with a dequeue
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced while idle");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

@@ hw/rtl/tpeq_dp.sv @@
// Datapath: config registers, coordinate mapping, contact table, event queue, result register.
module tpeq_dp #(
    parameter int MAX_CONTACTS = tpeq_pkg::MAX_CONTACTS_DEF,
    parameter int QUEUE_DEPTH  = tpeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  tpeq_pkg::t_in_word  i_in_word,
    input  tpeq_pkg::t_cmd      i_cmd,
    output tpeq_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpeq_pkg::t_out_word o_out_word
);
    import tpeq_pkg::*;

    localparam int CW  = $clog2(MAX_CONTACTS + 1);
    localparam int CAW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QAW = $clog2(QUEUE_DEPTH);

    // round(prod / 2^16) - offset, saturated to signed 16 bits
    function automatic logic [15:0] f_sat(input logic [39:0] prod,
                                          input logic signed [15:0] off);
        logic [24:0]        rnd;
        logic signed [26:0] v;
        rnd = 25'((prod + 40'h8000) >> 16);
        v   = $signed({2'b00, rnd}) - 27'(off);
        if (v > 27'sd32767)
            return 16'h7FFF;
        else if (v < -27'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    logic [23:0]        r_scale_x, r_scale_y;
    logic signed [15:0] r_off_x, r_off_y;
    logic [6:0]         r_move_limit;
    logic               r_enabled;

    t_in_word    r_item;
    logic [39:0] r_prod_x, r_prod_y;
    t_pos        r_pos;

    logic [MAX_CONTACTS-1:0] r_cvalid;
    t_cent                   m_cont [MAX_CONTACTS];
    t_cent                   r_crd;
    logic [CW-1:0]           r_ci;
    logic [CAW-1:0]          r_hit, r_slot;
    logic                    r_hit_ok, r_slot_ok;
    logic [15:0]             r_hit_ptr;

    t_qent          m_q [QUEUE_DEPTH];
    t_qent          r_qrd;
    logic [QW-1:0]  r_qcnt, r_mcnt, r_qi;

    logic [31:0] r_next_seq, r_ev_seq;
    logic [15:0] r_next_ptr, r_gen;
    logic        r_ovf;
    t_meta       r_ev_meta;
    t_pos        r_ev_pos;

    logic      r_ovalid;
    t_out_word r_out;

    logic [23:0]    s_key;
    logic [CAW-1:0] s_ci, s_cwa;
    t_cent          s_cwd;
    logic [QW-1:0]  s_qi_m1, s_qi_p1;
    logic [QAW-1:0] s_qra, s_qwa;
    t_qent          s_qwd;
    logic           s_qwe, s_full, s_rd_move, s_op_end;
    t_out_word      s_out_empty;

    assign s_key     = {r_item.source_device, r_item.source_contact};
    assign s_ci      = r_ci[CAW-1:0];
    assign s_qi_m1   = r_qi - QW'(1);
    assign s_qi_p1   = r_qi + QW'(1);
    assign s_full    = (r_qcnt == QW'(QUEUE_DEPTH));
    assign s_rd_move = (r_qrd.meta.phase == PH_MOVE);
    assign s_op_end  = (r_item.opcode == OP_UP) || (r_item.opcode == OP_CANCEL);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x    <= SCALE_RST;
            r_scale_y    <= SCALE_RST;
            r_off_x      <= '0;
            r_off_y      <= '0;
            r_move_limit <= MOVE_LIMIT_RST;
            r_enabled    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE_X:    r_scale_x    <= i_cfg_data;
                CFG_SCALE_Y:    r_scale_y    <= i_cfg_data;
                CFG_OFFSET_X:   r_off_x      <= i_cfg_data[15:0];
                CFG_OFFSET_Y:   r_off_y      <= i_cfg_data[15:0];
                CFG_MOVE_LIMIT: r_move_limit <= i_cfg_data[6:0];
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item and mapping pipe: product, then round/offset/saturate
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) r_item <= i_in_word;
        r_prod_x    <= {24'd0, r_item.phys_x} * {16'd0, r_scale_x};
        r_prod_y    <= {24'd0, r_item.phys_y} * {16'd0, r_scale_y};
        r_pos.x     <= f_sat(r_prod_x, r_off_x);
        r_pos.y     <= f_sat(r_prod_y, r_off_y);
        r_pos.press <= r_item.press;
    end

    // contact table memory
    assign s_cwa     = i_cmd.down_wr ? r_slot : r_hit;
    assign s_cwd.key = s_key;
    assign s_cwd.ptr = i_cmd.down_wr ? r_next_ptr : r_hit_ptr;
    assign s_cwd.pos = r_pos;

    always_ff @(posedge i_clk) begin
        r_crd <= m_cont[s_ci];
        if (i_cmd.down_wr || i_cmd.upd_wr) m_cont[s_cwa] <= s_cwd;
    end

    // event queue memory
    always_comb begin
        case (i_cmd.q_sel)
            QA_QI:    s_qra = r_qi[QAW-1:0];
            QA_QI_M1: s_qra = s_qi_m1[QAW-1:0];
            QA_QI_P1: s_qra = s_qi_p1[QAW-1:0];
            default:  s_qra = '0;
        endcase
    end

    assign s_qwe = (i_cmd.push && !s_full) || i_cmd.rm_wr;
    assign s_qwa = i_cmd.rm_wr ? r_qi[QAW-1:0] : r_qcnt[QAW-1:0];
    assign s_qwd = i_cmd.rm_wr ? r_qrd : t_qent'{meta: r_ev_meta, stamp: r_item.stamp,
                                                 pos: r_ev_pos, seq: r_ev_seq};

    always_ff @(posedge i_clk) begin
        r_qrd <= m_q[s_qra];
        if (s_qwe) m_q[s_qwa] <= s_qwd;
    end

    // scan results and pending event payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cmp) begin
            if (r_cvalid[s_ci] && r_crd.key == s_key && !r_hit_ok) begin
                r_hit     <= s_ci;
                r_hit_ptr <= r_crd.ptr;
            end
            if (!r_cvalid[s_ci] && !r_slot_ok) r_slot <= s_ci;
        end
        if (i_cmd.gen_inc) r_slot <= '0;
        if (i_cmd.down_wr) begin
            r_ev_meta <= '{gen: r_gen, ptr: r_next_ptr, phase: PH_DOWN};
            r_ev_pos  <= r_pos;
        end
        if (i_cmd.upd_wr) begin
            r_ev_meta <= '{gen: r_gen, ptr: r_hit_ptr, phase: r_item.opcode[1:0]};
            r_ev_pos  <= r_pos;
        end
        if (i_cmd.ca_ev) begin
            r_ev_meta <= '{gen: r_gen, ptr: r_crd.ptr, phase: PH_CANCEL};
            r_ev_pos  <= r_crd.pos;
        end
        if (i_cmd.ev_start) r_ev_seq <= r_next_seq;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid   <= '0;
            r_ci       <= '0;
            r_hit_ok   <= 1'b0;
            r_slot_ok  <= 1'b0;
            r_qcnt     <= '0;
            r_mcnt     <= '0;
            r_qi       <= '0;
            r_next_seq <= '0;
            r_next_ptr <= '0;
            r_gen      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cmd.ci_clr) begin
                r_ci      <= '0;
                r_hit_ok  <= 1'b0;
                r_slot_ok <= 1'b0;
            end else if (i_cmd.ci_inc) begin
                r_ci <= r_ci + CW'(1);
            end
            if (i_cmd.scan_cmp) begin
                if (r_cvalid[s_ci] && r_crd.key == s_key) r_hit_ok <= 1'b1;
                if (!r_cvalid[s_ci]) r_slot_ok <= 1'b1;
            end
            if (i_cmd.gen_inc) begin
                r_gen     <= r_gen + 16'd1;
                r_slot_ok <= 1'b1;
            end
            if (i_cmd.down_wr) begin
                r_cvalid[r_slot] <= 1'b1;
                r_next_ptr       <= r_next_ptr + 16'd1;
            end
            if (i_cmd.upd_wr && s_op_end) r_cvalid[r_hit] <= 1'b0;
            if (i_cmd.ca_ev) r_cvalid[s_ci] <= 1'b0;
            if (i_cmd.ev_start) r_next_seq <= r_next_seq + 32'd1;

            if (i_cmd.qi_load_cnt)  r_qi <= r_qcnt;
            else if (i_cmd.qi_clr)  r_qi <= '0;
            else if (i_cmd.qi_dec)  r_qi <= s_qi_m1;
            else if (i_cmd.qi_inc)  r_qi <= s_qi_p1;

            if (i_cmd.push) begin
                if (s_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_qcnt <= r_qcnt + QW'(1);
                    if (r_ev_meta.phase == PH_MOVE) r_mcnt <= r_mcnt + QW'(1);
                end
            end
            if (i_cmd.rm_done) r_qcnt <= r_qcnt - QW'(1);
            if (i_cmd.mc_dec) r_mcnt <= r_mcnt - QW'(1);
            if (i_cmd.out_load && s_rd_move && r_mcnt != '0) r_mcnt <= r_mcnt - QW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_empty || i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // empty-queue result: only the overflow flag is carried
    always_comb begin
        s_out_empty            = '0;
        s_out_empty.overflowed = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_empty) begin
            r_out <= s_out_empty;
        end else if (i_cmd.out_load) begin
            r_out.has_event      <= 1'b1;
            r_out.overflowed     <= r_ovf;
            r_out.seq_number     <= r_qrd.seq;
            r_out.gen_number     <= r_qrd.meta.gen;
            r_out.pointer_number <= r_qrd.meta.ptr;
            r_out.event_stamp    <= r_qrd.stamp;
            r_out.guest_x        <= r_qrd.pos.x;
            r_out.guest_y        <= r_qrd.pos.y;
            r_out.event_press    <= r_qrd.pos.press;
            r_out.event_phase    <= r_qrd.meta.phase;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    assign o_stat.op         = r_item.opcode;
    assign o_stat.enabled    = r_enabled;
    assign o_stat.ci_end     = (r_ci == CW'(MAX_CONTACTS));
    assign o_stat.cvalid     = r_cvalid[s_ci];
    assign o_stat.hit_ok     = r_hit_ok;
    assign o_stat.slot_ok    = r_slot_ok;
    assign o_stat.ev_move    = (r_ev_meta.phase == PH_MOVE);
    assign o_stat.limit_zero = (r_move_limit == 7'd0);
    assign o_stat.qi_zero    = (r_qi == '0);
    assign o_stat.qi_at_cnt  = (r_qi == r_qcnt);
    assign o_stat.meta_match = (r_qrd.meta == r_ev_meta);
    assign o_stat.rd_move    = s_rd_move;
    assign o_stat.limit_hit  = (32'(r_mcnt) >= 32'(r_move_limit));
    assign o_stat.q_empty    = (r_qcnt == '0);
    assign o_stat.rm_last    = (s_qi_p1 >= r_qcnt);
    assign o_stat.out_busy   = r_ovalid;

endmodule

@@ hw/rtl/tpeq_ctrl.sv @@
// Controller: sequences contact scans, cancel sweeps, move coalescing, dequeues, compaction.
module tpeq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tpeq_pkg::t_stat i_stat,
    output tpeq_pkg::t_cmd  o_cmd
);
    import tpeq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MAP1, S_MAP2, S_DISP, S_SC_RD, S_SC_CMP, S_DN, S_UPD,
        S_CA_CHK, S_CA_EV, S_CA_NEXT, S_EV_START, S_EV_MRD, S_EV_MCMP,
        S_EV_LIM, S_EV_LRD, S_EV_LCMP, S_EV_PUSH, S_EV_DONE, S_DQ, S_DQ_OUT,
        S_RM_CHK, S_RM_WR
    } t_state;

    typedef enum logic [1:0] {RET_IDLE, RET_LIM, RET_PUSH} t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic   r_in_ca, n_in_ca;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_IDLE;
            r_in_ca <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_in_ca <= n_in_ca;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_in_ca = r_in_ca;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_MAP1;
                end
            end
            S_MAP1: n_state = S_MAP2;
            S_MAP2: n_state = S_DISP;
            S_DISP: begin
                if (i_stat.op == OP_DEQUEUE) begin
                    n_state = S_DQ;
                end else if (i_stat.op == OP_CANCEL_ALL) begin
                    o_cmd.ci_clr = 1'b1;
                    n_in_ca      = 1'b1;
                    n_state      = S_CA_CHK;
                end else if (i_stat.op > OP_DEQUEUE || !i_stat.enabled) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ci_clr = 1'b1;
                    n_state      = S_SC_RD;
                end
            end
            S_SC_RD: begin
                if (!i_stat.ci_end) begin
                    n_state = S_SC_CMP;
                end else if (i_stat.op == OP_DOWN) begin
                    if (i_stat.hit_ok) begin
                        // down on a live contact: cancel everything first
                        o_cmd.ci_clr = 1'b1;
                        n_in_ca      = 1'b1;
                        n_state      = S_CA_CHK;
                    end else begin
                        n_state = S_DN;
                    end
                end else begin
                    n_state = i_stat.hit_ok ? S_UPD : S_IDLE;
                end
            end
            S_SC_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                o_cmd.ci_inc   = 1'b1;
                n_state        = S_SC_RD;
            end
            S_DN: begin
                if (i_stat.slot_ok) begin
                    o_cmd.down_wr = 1'b1;
                    n_state       = S_EV_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = S_EV_START;
            end
            S_CA_CHK: begin
                if (i_stat.ci_end) begin
                    o_cmd.gen_inc = 1'b1;
                    n_in_ca       = 1'b0;
                    n_state       = (i_stat.op == OP_DOWN) ? S_DN : S_IDLE;
                end else if (i_stat.cvalid) begin
                    n_state = S_CA_EV;
                end else begin
                    o_cmd.ci_inc = 1'b1;
                end
            end
            S_CA_EV: begin
                o_cmd.ca_ev = 1'b1;
                n_state     = S_EV_START;
            end
            S_CA_NEXT: begin
                o_cmd.ci_inc = 1'b1;
                n_state      = S_CA_CHK;
            end
            S_EV_START: begin
                o_cmd.ev_start = 1'b1;
                if (!i_stat.ev_move) begin
                    n_state = S_EV_PUSH;
                end else if (i_stat.limit_zero) begin
                    n_state = S_EV_DONE;
                end else begin
                    o_cmd.qi_load_cnt = 1'b1;
                    n_state           = S_EV_MRD;
                end
            end
            // newest-first search for a move of the same pointer and generation
            S_EV_MRD: begin
                if (i_stat.qi_zero) begin
                    n_state = S_EV_LIM;
                end else begin
                    o_cmd.q_sel = QA_QI_M1;
                    n_state     = S_EV_MCMP;
                end
            end
            S_EV_MCMP: begin
                o_cmd.qi_dec = 1'b1;
                if (i_stat.meta_match) begin
                    o_cmd.mc_dec = 1'b1;
                    n_ret        = RET_LIM;
                    n_state      = S_RM_CHK;
                end else begin
                    n_state = S_EV_MRD;
                end
            end
            S_EV_LIM: begin
                if (i_stat.limit_hit) begin
                    o_cmd.qi_clr = 1'b1;
                    n_state      = S_EV_LRD;
                end else begin
                    n_state = S_EV_PUSH;
                end
            end
            // oldest-first search for any move to evict
            S_EV_LRD: begin
                if (i_stat.qi_at_cnt) begin
                    n_state = S_EV_PUSH;
                end else begin
                    o_cmd.q_sel = QA_QI;
                    n_state     = S_EV_LCMP;
                end
            end
            S_EV_LCMP: begin
                if (i_stat.rd_move) begin
                    o_cmd.mc_dec = 1'b1;
                    n_ret        = RET_PUSH;
                    n_state      = S_RM_CHK;
                end else begin
                    o_cmd.qi_inc = 1'b1;
                    n_state      = S_EV_LRD;
                end
            end
            S_EV_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_EV_DONE;
            end
            S_EV_DONE: n_state = r_in_ca ? S_CA_NEXT : S_IDLE;
            S_DQ: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.q_empty) begin
                        o_cmd.out_empty = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.q_sel = QA_ZERO;
                        n_state     = S_DQ_OUT;
                    end
                end
            end
            S_DQ_OUT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.qi_clr   = 1'b1;
                n_ret          = RET_IDLE;
                n_state        = S_RM_CHK;
            end
            // compaction: shift entries above the hole down by one
            S_RM_CHK: begin
                if (i_stat.rm_last) begin
                    o_cmd.rm_done = 1'b1;
                    unique case (r_ret)
                        RET_LIM:  n_state = S_EV_LIM;
                        RET_PUSH: n_state = S_EV_PUSH;
                        default:  n_state = S_IDLE;
                    endcase
                end else begin
                    o_cmd.q_sel = QA_QI_P1;
                    n_state     = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_cmd.rm_wr  = 1'b1;
                o_cmd.qi_inc = 1'b1;
                n_state      = S_RM_CHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ dv/tb_touch_pointer_event_queue.sv @@
// Self-checking testbench for the touch pointer event queue.
`timescale 1ns / 100ps

module tb_touch_pointer_event_queue;
    import tpeq_pkg::*;

    localparam int NCON = MAX_CONTACTS_DEF;
    localparam int QDEP = QUEUE_DEPTH_DEF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_SCALE_X;
    logic [23:0] i_cfg_data = '0;

    touch_pointer_event_queue dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [23:0] m_scale_x, m_scale_y;
    logic [15:0] m_off_x, m_off_y;
    logic [6:0]  m_limit;
    logic        m_en;
    logic        c_valid [NCON];
    logic [23:0] c_key   [NCON];
    logic [15:0] c_ptr   [NCON];
    t_pos        c_pos   [NCON];
    t_qent       evq[$];
    int          moves;
    logic [31:0] seq_ctr;
    logic [15:0] ptr_ctr, gen_ctr;
    logic        ovf;

    t_in_word    pending[$];
    t_out_word   expected_words[$];
    int          errors = 0;
    bit          quiet = 0;      // no idling near the end
    bit          rx_hold = 0;    // long receiver hold-off
    bit          tx_pause = 0;

    task automatic add_word(t_in_word w);
        pending.insert(pending.size(), w);
    endtask

    function automatic t_in_word take_word();
        t_in_word w;
        w = pending[0];
        pending.delete(0);
        return w;
    endfunction

    function automatic logic [15:0] map_axis(logic [15:0] p, logic [23:0] s, logic [15:0] o);
        logic [63:0] prod;
        longint v;
        prod = ({48'd0, p} * {40'd0, s} + 64'h8000) >> 16;
        v = longint'(prod) - longint'($signed(o));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic queue_event(logic [1:0] ph, logic [15:0] ptr, t_pos pos, logic [47:0] st);
        t_qent e;
        e.meta = '{gen: gen_ctr, ptr: ptr, phase: ph};
        e.stamp = st;
        e.pos = pos;
        e.seq = seq_ctr;
        seq_ctr++;
        if (ph == PH_MOVE) begin
            if (m_limit == 0) return;
            for (int i = evq.size() - 1; i >= 0; i--) begin
                if (evq[i].meta == e.meta) begin
                    evq.delete(i);
                    moves--;
                    break;
                end
            end
            if (moves >= m_limit) begin
                for (int i = 0; i < evq.size(); i++) begin
                    if (evq[i].meta.phase == PH_MOVE) begin
                        evq.delete(i);
                        moves--;
                        break;
                    end
                end
            end
        end
        if (evq.size() >= QDEP) begin
            ovf = 1'b1;
            return;
        end
        evq.insert(evq.size(), e);
        if (ph == PH_MOVE) moves++;
    endtask

    task automatic cancel_contacts(logic [47:0] st);
        for (int i = 0; i < NCON; i++) begin
            if (c_valid[i]) begin
                queue_event(PH_CANCEL, c_ptr[i], c_pos[i], st);
                c_valid[i] = 1'b0;
            end
        end
        gen_ctr++;
    endtask

    task automatic predict_word(t_in_word w);
        t_pos       pos;
        t_out_word  r;
        logic [23:0] key;
        int hit, slot;
        key = {w.source_device, w.source_contact};
        pos.x = map_axis(w.phys_x, m_scale_x, m_off_x);
        pos.y = map_axis(w.phys_y, m_scale_y, m_off_y);
        pos.press = w.press;
        hit = NCON;
        slot = NCON;
        if (w.opcode == OP_DEQUEUE) begin
            r = '0;
            r.overflowed = ovf;
            if (evq.size() != 0) begin
                r.has_event = 1'b1;
                r.seq_number = evq[0].seq;
                r.gen_number = evq[0].meta.gen;
                r.pointer_number = evq[0].meta.ptr;
                r.event_stamp = evq[0].stamp;
                r.guest_x = evq[0].pos.x;
                r.guest_y = evq[0].pos.y;
                r.event_press = evq[0].pos.press;
                r.event_phase = evq[0].meta.phase;
                if (evq[0].meta.phase == PH_MOVE && moves > 0) moves--;
                evq.delete(0);
            end
            expected_words.insert(expected_words.size(), r);
            return;
        end
        if (w.opcode == OP_CANCEL_ALL) begin
            cancel_contacts(w.stamp);
            return;
        end
        if (w.opcode > OP_DEQUEUE || !m_en) return;
        for (int i = 0; i < NCON; i++) begin
            if (c_valid[i] && c_key[i] == key) begin
                hit = i;
                break;
            end
        end
        if (w.opcode == OP_DOWN) begin
            if (hit < NCON) cancel_contacts(w.stamp);
            for (int i = 0; i < NCON; i++) begin
                if (!c_valid[i]) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= NCON) return;
            c_valid[slot] = 1'b1;
            c_key[slot] = key;
            c_ptr[slot] = ptr_ctr;
            c_pos[slot] = pos;
            ptr_ctr++;
            queue_event(PH_DOWN, c_ptr[slot], pos, w.stamp);
            return;
        end
        if (hit >= NCON) return;
        c_pos[hit] = pos;
        queue_event(w.opcode[1:0], c_ptr[hit], pos, w.stamp);
        if (w.opcode == OP_UP || w.opcode == OP_CANCEL) c_valid[hit] = 1'b0;
    endtask

    // driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) predict_word(i_in_word);
            if (!(i_in_valid && o_in_stall)) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!tx_pause && pending.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word <= take_word();
                    if (!quiet && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 19);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    t_out_word e;
                    e = expected_words[0];
                    expected_words.delete(0);
                    if (o_out_word.has_event !== e.has_event) begin
                        $error("has_event exp %0h got %0h", e.has_event, o_out_word.has_event);
                        errors++;
                    end
                    if (o_out_word.overflowed !== e.overflowed) begin
                        $error("overflowed exp %0h got %0h", e.overflowed, o_out_word.overflowed);
                        errors++;
                    end
                    if (o_out_word.seq_number !== e.seq_number) begin
                        $error("seq_number exp %0h got %0h", e.seq_number, o_out_word.seq_number);
                        errors++;
                    end
                    if (o_out_word.gen_number !== e.gen_number) begin
                        $error("gen_number exp %0h got %0h", e.gen_number, o_out_word.gen_number);
                        errors++;
                    end
                    if (o_out_word.pointer_number !== e.pointer_number) begin
                        $error("pointer_number exp %0h got %0h", e.pointer_number,
                               o_out_word.pointer_number);
                        errors++;
                    end
                    if (o_out_word.event_stamp !== e.event_stamp) begin
                        $error("event_stamp exp %0h got %0h", e.event_stamp,
                               o_out_word.event_stamp);
                        errors++;
                    end
                    if (o_out_word.guest_x !== e.guest_x) begin
                        $error("guest_x exp %0h got %0h", e.guest_x, o_out_word.guest_x);
                        errors++;
                    end
                    if (o_out_word.guest_y !== e.guest_y) begin
                        $error("guest_y exp %0h got %0h", e.guest_y, o_out_word.guest_y);
                        errors++;
                    end
                    if (o_out_word.event_press !== e.event_press) begin
                        $error("event_press exp %0h got %0h", e.event_press,
                               o_out_word.event_press);
                        errors++;
                    end
                    if (o_out_word.event_phase !== e.event_phase) begin
                        $error("event_phase exp %0h got %0h", e.event_phase,
                               o_out_word.event_phase);
                        errors++;
                    end
                end
            end
            if (rx_hold) begin
                i_out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 19);
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCALE_X:    m_scale_x = val;
            CFG_SCALE_Y:    m_scale_y = val;
            CFG_OFFSET_X:   m_off_x = val[15:0];
            CFG_OFFSET_Y:   m_off_y = val[15:0];
            CFG_MOVE_LIMIT: m_limit = val[6:0];
            CFG_ENABLED:    m_en = val[0];
            default: ;
        endcase
    endtask

    // wait until all words are taken and all results are back, then let the block settle
    task automatic drain();
        wait (pending.size() == 0 && !i_in_valid && expected_words.size() == 0);
        repeat (6 * QDEP * 8) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [2:0] op, int dev, int con);
        t_in_word w;
        w.opcode = op;
        w.source_device = dev[15:0];
        w.source_contact = con[7:0];
        w.phys_x = 16'($urandom());
        w.phys_y = 16'($urandom());
        w.press = 16'($urandom());
        w.stamp = 48'({$urandom(), $urandom()});
        return w;
    endfunction

    // gesture-like traffic over a small key space, with a few stray opcodes
    task automatic push_random(int n);
        int r;
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            w = make_word(r < 15 ? OP_DOWN : r < 50 ? OP_MOVE : r < 60 ? OP_UP :
                          r < 64 ? OP_CANCEL : r < 66 ? OP_CANCEL_ALL :
                          r < 97 ? OP_DEQUEUE : 3'($urandom_range(6, 7)),
                          $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2),
                          $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 7));
            add_word(w);
        end
    endtask

    initial begin
        t_in_word w;
        m_scale_x = SCALE_RST;
        m_scale_y = SCALE_RST;
        m_off_x = '0;
        m_off_y = '0;
        m_limit = MOVE_LIMIT_RST;
        m_en = 1'b0;
        for (int i = 0; i < NCON; i++) c_valid[i] = 1'b0;
        moves = 0;
        seq_ctr = '0;
        ptr_ctr = '0;
        gen_ctr = '0;
        ovf = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: disabled submit, then extremes of mapping
        add_word(make_word(OP_DOWN, 1, 1));
        add_word(make_word(OP_DEQUEUE, 0, 0));
        drain();
        cfg_write(CFG_ENABLED, 24'd1);
        cfg_write(CFG_SCALE_X, 24'hFFFFFF);
        cfg_write(CFG_SCALE_Y, 24'd0);
        cfg_write(CFG_OFFSET_X, 24'h008000);
        cfg_write(CFG_OFFSET_Y, 24'h007FFF);
        w = make_word(OP_DOWN, 16'hFFFF, 8'hFF);
        w.phys_x = 16'hFFFF; w.phys_y = 16'h0000; w.press = 16'hFFFF;
        w.stamp = '1;
        add_word(w);
        w.opcode = OP_MOVE; w.phys_x = 16'd0; w.press = 16'd0; w.stamp = 48'd0;
        add_word(w);
        add_word(make_word(OP_MOVE, 16'hFFFF, 8'hFF));  // replaces queued move
        add_word(make_word(OP_MOVE, 5, 5));             // unknown contact
        add_word(make_word(OP_DOWN, 0, 0));
        add_word(make_word(OP_DOWN, 0, 0));             // down on active contact
        add_word(make_word(OP_UP, 0, 0));
        add_word(make_word(OP_CANCEL, 16'hFFFF, 8'hFF));
        add_word(make_word(3'd6, 0, 0));
        add_word(make_word(3'd7, 0, 0));
        for (int i = 0; i < 18; i++) add_word(make_word(OP_DOWN, 9, i)); // table full
        add_word(make_word(OP_CANCEL_ALL, 0, 0));
        for (int i = 0; i < 8; i++) add_word(make_word(OP_DEQUEUE, 0, 0));
        drain();

        // move limit zero, then overflow by filling past the queue depth
        cfg_write(CFG_SCALE_X, 24'h018000);
        cfg_write(CFG_SCALE_Y, 24'h010000);
        cfg_write(CFG_OFFSET_X, 24'h00FFF0);
        cfg_write(CFG_OFFSET_Y, 24'h000010);
        cfg_write(CFG_MOVE_LIMIT, 24'd0);
        add_word(make_word(OP_CANCEL_ALL, 0, 0));
        add_word(make_word(OP_DOWN, 1, 1));
        add_word(make_word(OP_MOVE, 1, 1));
        for (int i = 0; i < 40; i++) begin
            add_word(make_word(OP_DOWN, 2, i % 12));
            add_word(make_word(OP_UP, 2, i % 12));
        end
        // receiver holds off while the sender keeps offering
        for (int i = 0; i < 70; i++) add_word(make_word(OP_DEQUEUE, 0, 0));
        wait (pending.size() <= 70);
        rx_hold = 1;
        repeat (3000) @(posedge i_clk);
        rx_hold = 0;
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(CFG_SCALE_X, $urandom_range(0, 3) == 0 ? 24'($urandom()) :
                      24'($urandom_range(0, 20'hFFFFF)));
            cfg_write(CFG_SCALE_Y, 24'($urandom()));
            cfg_write(CFG_OFFSET_X, 24'($urandom()));
            cfg_write(CFG_OFFSET_Y, 24'($urandom()));
            cfg_write(CFG_MOVE_LIMIT, ph == 0 ? 24'd127 : ph == 1 ? 24'd1 :
                      24'($urandom_range(0, 64)));
            cfg_write(CFG_ENABLED, ph == 3 ? 24'd0 : 24'd1);
            add_word(make_word(OP_CANCEL_ALL, 0, 0));
            push_random(200);
            if (ph == 2) begin
                wait (pending.size() == 0);
                tx_pause = 1;
                wait (!i_in_valid && expected_words.size() == 0);
                tx_pause = 0;
            end
            drain();
        end
        quiet = 1;
        push_random(100);
        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
